FILE: hdl/nlt_pkg.sv
`default_nettype none
package nlt_pkg;

  localparam int unsigned MinPacketLen = 17;
  localparam int unsigned MaxRes = 8;
  localparam logic [31:0] ThresholdReset = 32'd2000;
  localparam logic [31:0] WarnReset = 32'd10000;

  typedef enum logic [2:0] {
    EV_SHORT  = 3'd0,
    EV_FULL   = 3'd1,
    EV_DISC   = 3'd2,
    EV_REJOIN = 3'd3,
    EV_RECV   = 3'd4,
    EV_OFF    = 3'd5,
    EV_STILL  = 3'd6,
    EV_QUIET  = 3'd7
  } event_t;

  typedef enum logic {
    KIND_PACKET = 1'b0,
    KIND_TICK   = 1'b1
  } kind_t;

  typedef enum logic {
    REG_THRESHOLD = 1'b0,
    REG_WARN      = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [15:0] node;
    logic        active;
    logic [31:0] last_seen;
    logic [31:0] off_since;
    logic [31:0] off_decl;
    logic [31:0] last_warn;
    logic [31:0] rx;
    logic [31:0] fail;
    logic [31:0] rejoins;
  } entry_t;

  typedef struct packed {
    event_t      ev;
    logic [15:0] node;
    logic        ok;
    logic [31:0] rx;
    logic [31:0] fail;
    logic [31:0] rejoins;
    logic [31:0] gap;
    logic [31:0] flag;
  } result_t;

  // per-cycle context handed from the sequencer to the head processor
  typedef struct packed {
    kind_t       kind;
    logic [15:0] sender;
    logic [31:0] now;
    logic        ok;
    logic        found;
    logic        head_valid;
    logic        alloc_slot;
    logic [31:0] threshold;
    logic [31:0] warn_period;
  } head_ctx_t;

  typedef struct packed {
    logic pkt_hit;
    logic tick_hit;
  } head_stat_t;

endpackage
`default_nettype wire

FILE: hdl/nlt_cell.sv
`default_nettype none
module nlt_cell (
  input  wire                  clk,
  input  wire                  shift_en,
  input  nlt_pkg::entry_t      ent_i,
  output nlt_pkg::entry_t      ent_o
);

  nlt_pkg::entry_t ent_r;

  // take the neighbor's entry on every walk step
  always_ff @(posedge clk) begin
    if (shift_en) begin
      ent_r <= ent_i;
    end
  end

  assign ent_o = ent_r;

endmodule
`default_nettype wire

FILE: hdl/nlt_head.sv
`default_nettype none
module nlt_head (
  input  nlt_pkg::head_ctx_t  ctx_i,
  input  nlt_pkg::entry_t     ent_i,
  output nlt_pkg::entry_t     ent_o,
  output nlt_pkg::result_t    res_o,
  output nlt_pkg::head_stat_t stat_o
);

  logic [31:0] gap_seen;
  logic [31:0] gap_warn;
  logic        match;

  assign gap_seen = ctx_i.now - ent_i.last_seen;
  assign gap_warn = ctx_i.now - ent_i.last_warn;
  assign match = ctx_i.head_valid && !ctx_i.found && (ent_i.node == ctx_i.sender);

  always_comb begin
    ent_o = ent_i;
    res_o = '0;
    res_o.node = ctx_i.sender;
    res_o.ok = ctx_i.ok;
    stat_o = '0;
    if (ctx_i.kind == nlt_pkg::KIND_PACKET) begin
      if (match) begin
        stat_o.pkt_hit = 1'b1;
        if (!ent_i.active) begin
          res_o.gap = ctx_i.now - ent_i.off_since;
          res_o.flag = ctx_i.now - ent_i.off_decl;
          ent_o.active = 1'b1;
          ent_o.rejoins = ent_i.rejoins + 32'd1;
          res_o.ev = nlt_pkg::EV_REJOIN;
        end else begin
          res_o.ev = nlt_pkg::EV_RECV;
        end
        ent_o.last_seen = ctx_i.now;
        ent_o.rx = ent_i.rx + 32'd1;
        ent_o.fail = ent_i.fail + {31'd0, !ctx_i.ok};
      end else if (!ctx_i.found && ctx_i.alloc_slot) begin
        stat_o.pkt_hit = 1'b1;
        ent_o = '0;
        ent_o.node = ctx_i.sender;
        ent_o.active = 1'b1;
        ent_o.last_seen = ctx_i.now;
        ent_o.rx = 32'd1;
        ent_o.fail = {31'd0, !ctx_i.ok};
        res_o.ev = nlt_pkg::EV_DISC;
      end
      res_o.rx = ent_o.rx;
      res_o.fail = ent_o.fail;
      res_o.rejoins = ent_o.rejoins;
    end else begin
      res_o.ok = 1'b0;
      res_o.node = ent_i.node;
      res_o.rx = ent_i.rx;
      res_o.fail = ent_i.fail;
      res_o.rejoins = ent_i.rejoins;
      res_o.gap = gap_seen;
      if (ctx_i.head_valid && ent_i.active && (gap_seen > ctx_i.threshold)) begin
        stat_o.tick_hit = 1'b1;
        ent_o.active = 1'b0;
        ent_o.off_since = ent_i.last_seen;
        ent_o.off_decl = ctx_i.now;
        ent_o.last_warn = ctx_i.now;
        res_o.ev = nlt_pkg::EV_OFF;
      end else if (ctx_i.head_valid && !ent_i.active && (gap_warn >= ctx_i.warn_period)) begin
        stat_o.tick_hit = 1'b1;
        ent_o.last_warn = ctx_i.now;
        res_o.ev = nlt_pkg::EV_STILL;
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/node_liveness_tracker_unit.sv
`default_nettype none
// A packet result is registered at the output after the walk of the entry ring;
// a short packet's result skips the walk. The input is accepted only in idle,
// so a new item waits until the last is done, as set by the walk through the
// single head processor, one entry per cycle; a tick walk also pauses while the result
// register is stalled. Reset (rst_n low, synchronous) empties the table and
// restores the threshold to 2000 ms and the warning period to 10000 ms.
module node_liveness_tracker_unit #(
  parameter int unsigned TABLE_DEPTH = 8
) (
  input  wire          clk,
  input  wire          rst_n,
  // configuration writes
  input  wire          cfg_we,
  input  wire          cfg_index,
  input  wire  [31:0]  cfg_data,
  // input stream
  input  wire          in_tvalid,
  output logic         in_tready,
  // tdata, low bit up: src_id[15:0], now_ms[47:16], pkt_len[58:48],
  // payload_node_id[74:59], payload_sequence[106:75],
  // payload_temperature[122:107], payload_humidity[138:123],
  // payload_battery[154:139], payload_uptime[186:155],
  // payload_check_byte[194:187], zero fill[199:195]
  input  wire  [199:0] in_tdata,
  // tuser: kind
  input  wire          in_tuser,
  // result stream
  output logic         out_tvalid,
  input  wire          out_tready,
  // tdata, low bit up: node_id[15:0], check_ok[16], received_count[48:17],
  // check_fail_count[80:49], rejoin_total[112:81], gap_ms[144:113],
  // flag_to_rejoin_ms[176:145], zero fill[183:177]
  output logic [183:0] out_tdata,
  // tuser: event_res
  output logic [2:0]   out_tuser,
  output logic         out_tlast
);

  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned NW = $clog2(nlt_pkg::MaxRes + 1);

  // configuration registers
  logic [31:0] threshold_r;
  logic [31:0] warn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= nlt_pkg::ThresholdReset;
      warn_r <= nlt_pkg::WarnReset;
    end else if (cfg_we) begin
      case (nlt_pkg::reg_idx_t'(cfg_index))
        nlt_pkg::REG_THRESHOLD: threshold_r <= cfg_data;
        nlt_pkg::REG_WARN:      warn_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // input unpacking and checksum fold over the sixteen payload bytes
  logic        in_xfer;
  logic [7:0]  cs;
  logic        short_pkt;
  logic        short_in;

  assign in_xfer = in_tvalid && in_tready;
  assign short_pkt = (in_tdata[58:48] < 11'(nlt_pkg::MinPacketLen));
  assign short_in = (nlt_pkg::kind_t'(in_tuser) == nlt_pkg::KIND_PACKET) && short_pkt;

  always_comb begin
    cs = '0;
    for (int b = 0; b < 16; b++) begin
      cs = cs ^ in_tdata[59 + 8*b +: 8];
    end
  end

  // sequencer state
  nlt_pkg::state_t  state_r, state_nxt;
  nlt_pkg::kind_t   kind_r;
  logic [15:0]      sender_r;
  logic [31:0]      now_r;
  logic             ok_r;
  logic             found_r;
  logic [CW-1:0]    step_r;
  logic [CW-1:0]    count_r;
  logic [NW-1:0]    nres_r;
  logic             pend_valid_r;
  nlt_pkg::result_t pend_r;
  nlt_pkg::result_t out_res_r;
  logic             out_valid_r;
  logic             out_last_r;

  logic             out_free;
  logic             walk_adv;
  logic             walk_end;

  assign out_free = !out_valid_r || out_tready;
  // hold a tick walk while the output register is full and not being taken
  assign walk_adv = (state_r == nlt_pkg::ST_WALK)
                 && ((kind_r == nlt_pkg::KIND_PACKET) || out_free);
  assign walk_end = (step_r == CW'(TABLE_DEPTH - 1));

  // entry ring: cell 0 is the head, the processed head re-enters at the tail
  nlt_pkg::entry_t     cell_q [TABLE_DEPTH];
  nlt_pkg::entry_t     head_nxt;
  nlt_pkg::result_t    head_res;
  nlt_pkg::head_stat_t head_stat;
  nlt_pkg::head_ctx_t  ctx;

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    nlt_pkg::entry_t cell_in;
    if (k == TABLE_DEPTH - 1) begin : g_tail
      assign cell_in = head_nxt;
    end else begin : g_mid
      assign cell_in = cell_q[k + 1];
    end
    nlt_cell u_cell (
      .clk      (clk),
      .shift_en (walk_adv),
      .ent_i    (cell_in),
      .ent_o    (cell_q[k])
    );
  end

  always_comb begin
    ctx.kind = kind_r;
    ctx.sender = sender_r;
    ctx.now = now_r;
    ctx.ok = ok_r;
    ctx.found = found_r;
    ctx.head_valid = (step_r < count_r);
    ctx.alloc_slot = (step_r == count_r);
    ctx.threshold = threshold_r;
    ctx.warn_period = warn_r;
  end

  nlt_head u_head (
    .ctx_i  (ctx),
    .ent_i  (cell_q[0]),
    .ent_o  (head_nxt),
    .res_o  (head_res),
    .stat_o (head_stat)
  );

  // report selection: short packet at accept, closing report at the end
  nlt_pkg::result_t short_res;
  nlt_pkg::result_t fin_res;
  logic             tick_take;
  logic             push_rep;
  logic             fin_load;
  logic             out_load;

  always_comb begin
    short_res = '0;
    short_res.ev = nlt_pkg::EV_SHORT;
    short_res.node = in_tdata[15:0];
    fin_res = '0;
    if (kind_r == nlt_pkg::KIND_TICK) begin
      fin_res.ev = nlt_pkg::EV_QUIET;
    end else begin
      fin_res.ev = nlt_pkg::EV_FULL;
      fin_res.node = sender_r;
      fin_res.ok = ok_r;
    end
  end

  // keep at most MaxRes tick reports; later hits still update their entries
  assign tick_take = head_stat.tick_hit && (nres_r < NW'(nlt_pkg::MaxRes));
  // a new tick report pushes the previous one out, not last
  assign push_rep = walk_adv && tick_take && pend_valid_r;
  assign fin_load = (state_r == nlt_pkg::ST_DONE) && out_free;
  assign out_load = push_rep || fin_load;

  assign in_tready = (state_r == nlt_pkg::ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      nlt_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (short_in) begin
            state_nxt = nlt_pkg::ST_DONE;
          end else begin
            state_nxt = nlt_pkg::ST_WALK;
          end
        end
      end
      nlt_pkg::ST_WALK: begin
        if (walk_adv && walk_end) begin
          state_nxt = nlt_pkg::ST_DONE;
        end
      end
      nlt_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = nlt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = nlt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nlt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // item context, walk counters, the pending report and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      step_r <= '0;
      found_r <= 1'b0;
      nres_r <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      out_last_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        nlt_pkg::ST_IDLE: begin
          if (in_xfer) begin
            kind_r <= nlt_pkg::kind_t'(in_tuser);
            sender_r <= in_tdata[15:0];
            now_r <= in_tdata[47:16];
            ok_r <= (cs == in_tdata[194:187]);
            step_r <= '0;
            found_r <= 1'b0;
            nres_r <= '0;
            pend_valid_r <= short_in;
            pend_r <= short_res;
          end
        end
        nlt_pkg::ST_WALK: begin
          if (walk_adv) begin
            step_r <= step_r + CW'(1);
            if (head_stat.pkt_hit) begin
              found_r <= 1'b1;
              if (!ctx.head_valid) begin
                count_r <= count_r + CW'(1);
              end
            end
            if (head_stat.pkt_hit || tick_take) begin
              pend_valid_r <= 1'b1;
              pend_r <= head_res;
            end
            if (tick_take) begin
              nres_r <= nres_r + NW'(1);
            end
            if (push_rep) begin
              out_res_r <= pend_r;
              out_last_r <= 1'b0;
            end
          end
        end
        nlt_pkg::ST_DONE: begin
          if (fin_load) begin
            out_last_r <= 1'b1;
            pend_valid_r <= 1'b0;
            out_res_r <= pend_valid_r ? pend_r : fin_res;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast = out_last_r;
  assign out_tuser = out_res_r.ev;
  assign out_tdata = {7'd0, out_res_r.flag, out_res_r.gap, out_res_r.rejoins,
                      out_res_r.fail, out_res_r.rx, out_res_r.ok, out_res_r.node};

endmodule
`default_nettype wire
